// ===== hdl/bdlm_pkg.sv =====
// ----------------------------------------------------------------------------
// bdlm_pkg
// Shared codes and field widths for the bucketed draw-list manager.
// ----------------------------------------------------------------------------
package bdlm_pkg;

   localparam int CMD_W       = 2;
   localparam int STATUS_W    = 2;
   localparam int LIST_NUM_W  = 6;
   localparam int OBJ_W       = 32;
   localparam int NODE_IDX_W  = 8;
   localparam int POOL_SIZE_W = 9;

   // number of list_number codes on the request port
   localparam int LIST_CODES = 64;

   localparam logic [POOL_SIZE_W-1:0] POOL_SIZE_RESET = 9'd256;

   localparam logic [CMD_W-1:0] CMD_APPEND     = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RESET      = 2'd1;
   localparam logic [CMD_W-1:0] CMD_WALK_BEGIN = 2'd2;
   localparam logic [CMD_W-1:0] CMD_WALK_NEXT  = 2'd3;

   localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_EXHAUSTED = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_WALK_DONE = 2'd2;

endpackage

// ===== hdl/bdlm_node_store.sv =====
// ----------------------------------------------------------------------------
// bdlm_node_store
// Node pool storage: object handle and next link per node, one write
// address and one registered read port.
// ----------------------------------------------------------------------------
module bdlm_node_store #(
   parameter int DEPTH  = 256,
   parameter int LINK_W = 9
) (
   input  logic                           clock,
   input  logic                           obj_we,
   input  logic                           link_we,
   input  logic [$clog2(DEPTH)-1:0]       wr_addr,
   input  logic [bdlm_pkg::OBJ_W-1:0]     obj_wdata,
   input  logic [LINK_W-1:0]              link_wdata,
   input  logic                           rd_en,
   input  logic [$clog2(DEPTH)-1:0]       rd_addr,
   output logic [bdlm_pkg::OBJ_W-1:0]     obj_rdata,
   output logic [LINK_W-1:0]              link_rdata
);

   logic [bdlm_pkg::OBJ_W-1:0] obj_mem  [DEPTH];
   logic [LINK_W-1:0]          link_mem [DEPTH];

   logic [bdlm_pkg::OBJ_W-1:0] obj_rd_ff;
   logic [LINK_W-1:0]          link_rd_ff;

   always_ff @(posedge clock) begin
      if (obj_we) begin
         obj_mem[wr_addr] <= obj_wdata;
      end
      if (rd_en) begin
         obj_rd_ff <= obj_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[wr_addr] <= link_wdata;
      end
      if (rd_en) begin
         link_rd_ff <= link_mem[rd_addr];
      end
   end

   assign obj_rdata  = obj_rd_ff;
   assign link_rdata = link_rd_ff;

endmodule

// ===== hdl/bucketed_draw_list_manager.sv =====
// Each command gives one result beat on rsp_strobe. Reset screen, exhausted append
// and walk next with no walk active answer from idle; begin walk reads the head of
// list 0; append reads the tail entry, then links the old tail if the list was not
// empty. Walk next skips lists with an empty cursor or at a zero handle until it
// lands on a node in the current list. One command at a time: busy is high until
// the result beat is registered. The receiver cannot stall. Reset (synchronous)
// empties all lists at once, pool_size back to 256.
// ----------------------------------------------------------------------------
// bucketed_draw_list_manager
// Node pool feeding tail-append ordered lists per screen, with an in-order
// walk over one screen's lists.
// ----------------------------------------------------------------------------
module bucketed_draw_list_manager #(
   parameter int POOL_DEPTH       = 256,
   parameter int LISTS_PER_SCREEN = 64,
   parameter int SCREENS          = 2
) (
   input  logic                                clock,
   input  logic                                reset,
   // command beat
   input  logic                                start,
   output logic                                busy,
   input  logic [bdlm_pkg::CMD_W-1:0]          req_cmd,
   input  logic                                req_screen_select,
   input  logic [bdlm_pkg::LIST_NUM_W-1:0]     req_list_number,
   input  logic [bdlm_pkg::OBJ_W-1:0]          req_object_handle,
   // result beat
   output logic                                rsp_strobe,
   output logic [bdlm_pkg::STATUS_W-1:0]       rsp_status,
   output logic [bdlm_pkg::NODE_IDX_W-1:0]     rsp_node_index,
   output logic [bdlm_pkg::OBJ_W-1:0]          rsp_object_out,
   output logic [bdlm_pkg::LIST_NUM_W-1:0]     rsp_walk_list,
   // pool_size register
   input  logic                                csr_write_enable,
   input  logic [bdlm_pkg::POOL_SIZE_W-1:0]    csr_write_data
);

   // ------------------------------------------------------------------------
   // widths
   // ------------------------------------------------------------------------
   localparam int AW        = $clog2(POOL_DEPTH);          // node address
   localparam int NW        = $clog2(POOL_DEPTH + 1);      // node or NIL
   localparam int NUM_LISTS = SCREENS * LISTS_PER_SCREEN;
   localparam int SLW       = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
   localparam int SW        = (SCREENS > 1) ? $clog2(SCREENS) : 1;
   localparam int LW        = (LISTS_PER_SCREEN > 1) ? $clog2(LISTS_PER_SCREEN) : 1;
   localparam int CLW       = $clog2(LISTS_PER_SCREEN + 1); // cursor, LISTS = idle
   localparam int CMPW      = (NW > bdlm_pkg::POOL_SIZE_W) ? NW : bdlm_pkg::POOL_SIZE_W;

   localparam logic [NW-1:0]  NIL      = NW'(POOL_DEPTH);
   localparam logic [CLW-1:0] LIST_END = CLW'(LISTS_PER_SCREEN);

   // sequencer states
   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_APP_RD   = 3'd1;  // tail entry arriving
   localparam logic [2:0] ST_APP_LINK = 3'd2;  // patch old tail's link
   localparam logic [2:0] ST_WLK_STEP = 3'd3;  // decide: read node or next list
   localparam logic [2:0] ST_WLK_NODE = 3'd4;  // node entry arriving
   localparam logic [2:0] ST_WLK_HEAD = 3'd5;  // head of next list arriving
   localparam logic [2:0] ST_BEG_HEAD = 3'd6;  // head of list 0 arriving

   // ------------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------------
   logic [2:0]                          state_ff, state_in;
   logic [bdlm_pkg::POOL_SIZE_W-1:0]    pool_size_ff;
   logic [NW-1:0]                       alloc_next_ff, alloc_next_in;
   logic [NW-1:0]                       cur_node_ff, cur_node_in;
   logic [CLW-1:0]                      cur_list_ff, cur_list_in;
   logic [SW-1:0]                       cur_scr_ff, cur_scr_in;
   logic [NUM_LISTS-1:0]                valid_ff, valid_in;

   // operands of the append in flight
   logic [NW-1:0]                       op_node_ff, op_node_in;
   logic [NW-1:0]                       op_tail_ff, op_tail_in;
   logic [SLW-1:0]                      op_slot_ff, op_slot_in;
   logic [bdlm_pkg::OBJ_W-1:0]          op_obj_ff, op_obj_in;

   // result beat
   logic                                rsp_strobe_ff, rsp_strobe_in;
   logic [bdlm_pkg::STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [bdlm_pkg::NODE_IDX_W-1:0]     rsp_node_ff, rsp_node_in;
   logic [bdlm_pkg::OBJ_W-1:0]          rsp_obj_ff, rsp_obj_in;
   logic [bdlm_pkg::LIST_NUM_W-1:0]     rsp_wl_ff, rsp_wl_in;

   // ------------------------------------------------------------------------
   // list directory: {head, tail} per list, valid bit per list in flops.
   // An entry whose valid bit is clear reads as an empty list.
   // ------------------------------------------------------------------------
   logic [2*NW-1:0]  list_mem [NUM_LISTS];
   logic [2*NW-1:0]  list_rd_ff;
   logic             list_vld_ff;
   logic             list_rd_en;
   logic [SLW-1:0]   list_rd_addr;
   logic             list_we;
   logic [2*NW-1:0]  list_wdata;

   always_ff @(posedge clock) begin
      if (list_we) begin
         list_mem[op_slot_ff] <= list_wdata;
      end
      if (list_rd_en) begin
         list_rd_ff  <= list_mem[list_rd_addr];
         list_vld_ff <= valid_ff[list_rd_addr];
      end
   end

   logic [NW-1:0] head_eff;
   logic [NW-1:0] tail_eff;
   assign head_eff = list_vld_ff ? list_rd_ff[2*NW-1:NW] : NIL;
   assign tail_eff = list_vld_ff ? list_rd_ff[NW-1:0]    : NIL;

   // ------------------------------------------------------------------------
   // node store
   // ------------------------------------------------------------------------
   logic                         obj_we;
   logic                         link_we;
   logic [AW-1:0]                node_wr_addr;
   logic [bdlm_pkg::OBJ_W-1:0]   obj_wdata;
   logic [NW-1:0]                link_wdata;
   logic                         node_rd_en;
   logic [AW-1:0]                node_rd_addr;
   logic [bdlm_pkg::OBJ_W-1:0]   obj_rdata;
   logic [NW-1:0]                link_rdata;

   bdlm_node_store #(
      .DEPTH  (POOL_DEPTH),
      .LINK_W (NW)
   ) u_node_store (
      .clock      (clock),
      .obj_we     (obj_we),
      .link_we    (link_we),
      .wr_addr    (node_wr_addr),
      .obj_wdata  (obj_wdata),
      .link_wdata (link_wdata),
      .rd_en      (node_rd_en),
      .rd_addr    (node_rd_addr),
      .obj_rdata  (obj_rdata),
      .link_rdata (link_rdata)
   );

   // ------------------------------------------------------------------------
   // request decode
   // ------------------------------------------------------------------------
   // list_number folded into range by a constant table
   logic [LW-1:0] list_mod_tbl [bdlm_pkg::LIST_CODES];
   for (genvar g = 0; g < bdlm_pkg::LIST_CODES; g++) begin : g_list_mod
      assign list_mod_tbl[g] = LW'(g % LISTS_PER_SCREEN);
   end

   function automatic logic [SLW-1:0] slot_of(input logic [SW-1:0] scr,
                                              input logic [LW-1:0] lst);
      return SLW'(int'(scr) * LISTS_PER_SCREEN + int'(lst));
   endfunction

   logic [SW-1:0]  req_scr;
   logic [LW-1:0]  req_lst;
   logic [SLW-1:0] req_slot;

   assign req_scr  = (SCREENS == 1) ? '0 : SW'(req_screen_select);
   assign req_lst  = list_mod_tbl[req_list_number];
   assign req_slot = slot_of(req_scr, req_lst);

   // pool exhausted: pool_size 0 acts as 1, above POOL_DEPTH acts as POOL_DEPTH
   logic [CMPW-1:0] an_cmp;
   logic [CMPW-1:0] ps_cmp;
   logic            exhausted;

   assign an_cmp    = CMPW'(alloc_next_ff);
   assign ps_cmp    = CMPW'(pool_size_ff);
   assign exhausted = (an_cmp >= CMPW'(POOL_DEPTH))
                   || ((ps_cmp != '0) && (an_cmp >= ps_cmp))
                   || ((ps_cmp == '0) && (an_cmp != '0));

   logic [CLW-1:0] next_list;
   assign next_list = cur_list_ff + CLW'(1);

   // ------------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------------
   logic adv;  // move walk cursor to the next list

   always_comb begin
      state_in      = state_ff;
      alloc_next_in = alloc_next_ff;
      cur_node_in   = cur_node_ff;
      cur_list_in   = cur_list_ff;
      cur_scr_in    = cur_scr_ff;
      valid_in      = valid_ff;
      op_node_in    = op_node_ff;
      op_tail_in    = op_tail_ff;
      op_slot_in    = op_slot_ff;
      op_obj_in     = op_obj_ff;

      rsp_strobe_in = 1'b0;
      rsp_status_in = bdlm_pkg::STAT_OK;
      rsp_node_in   = '0;
      rsp_obj_in    = '0;
      rsp_wl_in     = '0;

      list_rd_en    = 1'b0;
      list_rd_addr  = '0;
      list_we       = 1'b0;
      list_wdata    = '0;
      obj_we        = 1'b0;
      link_we       = 1'b0;
      node_wr_addr  = '0;
      obj_wdata     = '0;
      link_wdata    = '0;
      node_rd_en    = 1'b0;
      node_rd_addr  = '0;
      adv           = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_cmd)
                  bdlm_pkg::CMD_APPEND: begin
                     if (exhausted) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = bdlm_pkg::STAT_EXHAUSTED;
                     end else begin
                        list_rd_en    = 1'b1;
                        list_rd_addr  = req_slot;
                        op_slot_in    = req_slot;
                        op_node_in    = alloc_next_ff;
                        op_obj_in     = req_object_handle;
                        alloc_next_in = alloc_next_ff + NW'(1);
                        state_in      = ST_APP_RD;
                     end
                  end
                  bdlm_pkg::CMD_RESET: begin
                     // empty this screen's lists, whole pool back to free
                     for (int i = 0; i < NUM_LISTS; i++) begin
                        if (SW'(i / LISTS_PER_SCREEN) == req_scr) begin
                           valid_in[i] = 1'b0;
                        end
                     end
                     alloc_next_in = '0;
                     if (cur_scr_ff == req_scr) begin
                        cur_list_in = LIST_END;
                        cur_node_in = NIL;
                     end
                     rsp_strobe_in = 1'b1;
                  end
                  bdlm_pkg::CMD_WALK_BEGIN: begin
                     cur_scr_in   = req_scr;
                     cur_list_in  = '0;
                     list_rd_en   = 1'b1;
                     list_rd_addr = slot_of(req_scr, '0);
                     state_in     = ST_BEG_HEAD;
                  end
                  bdlm_pkg::CMD_WALK_NEXT: begin
                     if (cur_list_ff >= LIST_END) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = bdlm_pkg::STAT_WALK_DONE;
                     end else begin
                        state_in = ST_WLK_STEP;
                     end
                  end
                  default: ;
               endcase
            end
         end

         ST_APP_RD: begin
            // new node is the tail; it becomes the head too if the list was empty
            obj_we       = 1'b1;
            link_we      = 1'b1;
            node_wr_addr = AW'(op_node_ff);
            obj_wdata    = op_obj_ff;
            link_wdata   = NIL;
            list_we      = 1'b1;
            list_wdata   = {((tail_eff == NIL) ? op_node_ff : head_eff), op_node_ff};
            valid_in[op_slot_ff] = 1'b1;
            op_tail_in   = tail_eff;
            if (tail_eff == NIL) begin
               rsp_strobe_in = 1'b1;
               rsp_node_in   = bdlm_pkg::NODE_IDX_W'(op_node_ff);
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_APP_LINK;
            end
         end

         ST_APP_LINK: begin
            link_we       = 1'b1;
            node_wr_addr  = AW'(op_tail_ff);
            link_wdata    = op_node_ff;
            rsp_strobe_in = 1'b1;
            rsp_node_in   = bdlm_pkg::NODE_IDX_W'(op_node_ff);
            state_in      = ST_IDLE;
         end

         ST_WLK_STEP: begin
            if (cur_node_ff != NIL) begin
               node_rd_en   = 1'b1;
               node_rd_addr = AW'(cur_node_ff);
               state_in     = ST_WLK_NODE;
            end else begin
               adv = 1'b1;
            end
         end

         ST_WLK_NODE: begin
            // a zero handle ends the list
            if (obj_rdata != '0) begin
               rsp_strobe_in = 1'b1;
               rsp_node_in   = bdlm_pkg::NODE_IDX_W'(cur_node_ff);
               rsp_obj_in    = obj_rdata;
               rsp_wl_in     = bdlm_pkg::LIST_NUM_W'(cur_list_ff);
               cur_node_in   = link_rdata;
               state_in      = ST_IDLE;
            end else begin
               adv = 1'b1;
            end
         end

         ST_WLK_HEAD: begin
            cur_node_in = head_eff;
            state_in    = ST_WLK_STEP;
         end

         ST_BEG_HEAD: begin
            cur_node_in   = head_eff;
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (adv) begin
         if (next_list == LIST_END) begin
            cur_list_in   = LIST_END;
            cur_node_in   = NIL;
            rsp_strobe_in = 1'b1;
            rsp_status_in = bdlm_pkg::STAT_WALK_DONE;
            state_in      = ST_IDLE;
         end else begin
            cur_list_in  = next_list;
            cur_node_in  = NIL;
            list_rd_en   = 1'b1;
            list_rd_addr = slot_of(cur_scr_ff, LW'(next_list));
            state_in     = ST_WLK_HEAD;
         end
      end
   end

   // ------------------------------------------------------------------------
   // control state
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pool_size_ff  <= bdlm_pkg::POOL_SIZE_RESET;
         alloc_next_ff <= '0;
         cur_node_ff   <= NIL;
         cur_list_ff   <= LIST_END;
         cur_scr_ff    <= '0;
         valid_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         alloc_next_ff <= alloc_next_in;
         cur_node_ff   <= cur_node_in;
         cur_list_ff   <= cur_list_in;
         cur_scr_ff    <= cur_scr_in;
         valid_ff      <= valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_write_enable) begin
            pool_size_ff <= csr_write_data;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      op_node_ff    <= op_node_in;
      op_tail_ff    <= op_tail_in;
      op_slot_ff    <= op_slot_in;
      op_obj_ff     <= op_obj_in;
      rsp_status_ff <= rsp_status_in;
      rsp_node_ff   <= rsp_node_in;
      rsp_obj_ff    <= rsp_obj_in;
      rsp_wl_ff     <= rsp_wl_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_node_index = rsp_node_ff;
   assign rsp_object_out = rsp_obj_ff;
   assign rsp_walk_list  = rsp_wl_ff;

endmodule

// ===== tb/bucketed_draw_list_manager_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bucketed_draw_list_manager_tb
// Self-checking bench for the draw-list manager. Command beats are driven on
// the falling edge and held until busy is seen low at a rising edge. Every
// accepted beat runs through a local list predictor (node pool, per-screen
// list heads/tails, walk cursor), and each result beat is compared against
// the oldest awaited result. A short directed table opens the run, then
// random phases under a range of pool sizes, the extremes included.
// ----------------------------------------------------------------------------
module bucketed_draw_list_manager_tb;

   localparam int POOL_NODES = 256;
   localparam int SCREEN_LISTS = 64;
   localparam int ALL_LISTS = 2 * SCREEN_LISTS;
   // empty head / own-sentinel tail / end-of-list link
   localparam logic [8:0] NIL = 9'd256;
   // idle time at the end of the run, after the last awaited result beat
   localparam int SETTLE_CYCLES = 300;
   localparam int RANDOM_ITEMS = 1550;

   typedef struct packed {
      logic [bdlm_pkg::STATUS_W-1:0]   status;
      logic [bdlm_pkg::NODE_IDX_W-1:0] node;
      logic [bdlm_pkg::OBJ_W-1:0]      obj;
      logic [bdlm_pkg::LIST_NUM_W-1:0] wlist;
   } draw_result_type;

   // one row of the directed table: either a pool_size write or a command beat
   typedef struct packed {
      bit                               is_csr;
      logic [bdlm_pkg::POOL_SIZE_W-1:0] pool;
      logic [bdlm_pkg::CMD_W-1:0]       cmd;
      logic                             scr;
      logic [bdlm_pkg::LIST_NUM_W-1:0]  lst;
      logic [bdlm_pkg::OBJ_W-1:0]       obj;
      bit                               typed;
      draw_result_type                  want;
   } stim_row_type;

   // ------------------------------------------------------------------------
   // DUT hookup; every input starts at a known value
   // ------------------------------------------------------------------------
   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             start = 1'b0;
   logic                             busy;
   logic [bdlm_pkg::CMD_W-1:0]       req_cmd = bdlm_pkg::CMD_APPEND;
   logic                             req_screen_select = 1'b0;
   logic [bdlm_pkg::LIST_NUM_W-1:0]  req_list_number = '0;
   logic [bdlm_pkg::OBJ_W-1:0]       req_object_handle = '0;
   logic                             rsp_strobe;
   logic [bdlm_pkg::STATUS_W-1:0]    rsp_status;
   logic [bdlm_pkg::NODE_IDX_W-1:0]  rsp_node_index;
   logic [bdlm_pkg::OBJ_W-1:0]       rsp_object_out;
   logic [bdlm_pkg::LIST_NUM_W-1:0]  rsp_walk_list;
   logic                             csr_write_enable = 1'b0;
   logic [bdlm_pkg::POOL_SIZE_W-1:0] csr_write_data = '0;

   bucketed_draw_list_manager dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (req_cmd),
      .req_screen_select (req_screen_select),
      .req_list_number   (req_list_number),
      .req_object_handle (req_object_handle),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_node_index    (rsp_node_index),
      .rsp_object_out    (rsp_object_out),
      .rsp_walk_list     (rsp_walk_list),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Predictor state: a copy of the pool, the list directory and the walk
   // cursor. Nodes read as 0 until written.
   // ------------------------------------------------------------------------
   logic [bdlm_pkg::POOL_SIZE_W-1:0] pool_cfg;
   logic [8:0]                       alloc_cnt;
   bit   [bdlm_pkg::OBJ_W-1:0]       node_obj [POOL_NODES];
   bit   [8:0]                       node_nxt [POOL_NODES];
   logic [8:0]                       list_head [ALL_LISTS];
   logic [8:0]                       list_tail [ALL_LISTS];
   logic [8:0]                       cur_node;
   logic [6:0]                       cur_list;
   logic                             cur_scr;

   draw_result_type awaited [$];
   stim_row_type    dir_rows [$];

   int idle_pct = 34;
   int mismatches = 0;
   int commands_sent = 0;
   int item_target = 0;
   int appends_ok = 0;
   int appends_refused = 0;
   int walk_hits = 0;
   int screen_clears = 0;
   int pool_writes = 0;

   // Applies one command to the local copy and returns the result beat it
   // should produce.
   function automatic draw_result_type predict_list_op(
         input logic [bdlm_pkg::CMD_W-1:0] cmd,
         input logic scr,
         input logic [bdlm_pkg::LIST_NUM_W-1:0] lst,
         input logic [bdlm_pkg::OBJ_W-1:0] obj);
      draw_result_type r;
      logic [8:0]      cap;
      logic [8:0]      n;
      logic [6:0]      slot;
      int              i;
      r = '0;
      slot = {scr, lst};
      case (cmd)
         bdlm_pkg::CMD_APPEND: begin
            // pool_size 0 acts as 1, anything past the pool as the pool
            cap = (pool_cfg == 0) ? 9'd1 : ((pool_cfg > NIL) ? NIL : pool_cfg);
            if (alloc_cnt >= cap) begin
               r.status = bdlm_pkg::STAT_EXHAUSTED;
            end else begin
               n = alloc_cnt;
               alloc_cnt = alloc_cnt + 9'd1;
               node_obj[n[7:0]] = obj;
               node_nxt[n[7:0]] = NIL;
               if (list_tail[slot] != NIL) node_nxt[list_tail[slot][7:0]] = n;
               else list_head[slot] = n;
               list_tail[slot] = n;
               r.node = n[7:0];
            end
         end
         bdlm_pkg::CMD_RESET: begin
            // only this screen's lists are emptied; the whole pool is freed
            for (i = 0; i < SCREEN_LISTS; i++) begin
               list_head[{scr, i[5:0]}] = NIL;
               list_tail[{scr, i[5:0]}] = NIL;
            end
            alloc_cnt = '0;
            if (cur_scr == scr) begin
               cur_list = 7'(SCREEN_LISTS);
               cur_node = NIL;
            end
         end
         bdlm_pkg::CMD_WALK_BEGIN: begin
            cur_scr = scr;
            cur_list = '0;
            cur_node = list_head[{scr, 6'd0}];
         end
         default: begin
            // walk next: skip empty lists and lists ended by a zero handle
            r.status = bdlm_pkg::STAT_WALK_DONE;
            while (cur_list < SCREEN_LISTS) begin
               n = cur_node;
               if (n != NIL && node_obj[n[7:0]] != 0) begin
                  r.status = bdlm_pkg::STAT_OK;
                  r.node = n[7:0];
                  r.obj = node_obj[n[7:0]];
                  r.wlist = cur_list[5:0];
                  cur_node = node_nxt[n[7:0]];
                  break;
               end
               cur_list = cur_list + 7'd1;
               cur_node = NIL;
               if (cur_list < SCREEN_LISTS) cur_node = list_head[{cur_scr, cur_list[5:0]}];
            end
         end
      endcase
      return r;
   endfunction

   function automatic stim_row_type op_row(input logic [bdlm_pkg::CMD_W-1:0] cmd,
                                           input logic scr,
                                           input logic [bdlm_pkg::LIST_NUM_W-1:0] lst,
                                           input logic [bdlm_pkg::OBJ_W-1:0] obj,
                                           input bit typed, input draw_result_type want);
      stim_row_type row;
      row = '0;
      row.cmd = cmd;
      row.scr = scr;
      row.lst = lst;
      row.obj = obj;
      row.typed = typed;
      row.want = want;
      return row;
   endfunction

   function automatic stim_row_type pool_row(input logic [bdlm_pkg::POOL_SIZE_W-1:0] v);
      stim_row_type row;
      row = '0;
      row.is_csr = 1'b1;
      row.pool = v;
      return row;
   endfunction

   // mostly a handful of lists so they grow long; sometimes any list
   function automatic logic [bdlm_pkg::LIST_NUM_W-1:0] pick_list();
      if ($urandom_range(0, 3) == 0) return bdlm_pkg::LIST_NUM_W'($urandom_range(0, 63));
      return bdlm_pkg::LIST_NUM_W'($urandom_range(0, 7));
   endfunction

   // zero handles cut walks short, so they show up now and then
   function automatic logic [bdlm_pkg::OBJ_W-1:0] pick_handle();
      int r;
      r = $urandom_range(0, 99);
      if (r < 6) return '0;
      if (r < 10) return '1;
      return $urandom;
   endfunction

   // ------------------------------------------------------------------------
   // Command driver. Entered just after a rising edge; returns at the edge
   // that accepted the beat, with start still high so back-to-back beats
   // need no extra assignment.
   // ------------------------------------------------------------------------
   task automatic send_command(input logic [bdlm_pkg::CMD_W-1:0] cmd, input logic scr,
                               input logic [bdlm_pkg::LIST_NUM_W-1:0] lst,
                               input logic [bdlm_pkg::OBJ_W-1:0] obj,
                               input bit typed, input draw_result_type typed_want,
                               output draw_result_type predicted);
      while ($urandom_range(0, 99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
         @(posedge clock);
      end
      @(negedge clock);
      start <= 1'b1;
      req_cmd <= cmd;
      req_screen_select <= scr;
      req_list_number <= lst;
      req_object_handle <= obj;
      do @(posedge clock); while (busy);
      predicted = predict_list_op(cmd, scr, lst, obj);
      awaited.push_back(typed ? typed_want : predicted);
      commands_sent++;
      if (cmd == bdlm_pkg::CMD_APPEND && predicted.status == bdlm_pkg::STAT_OK)
         appends_ok++;
      if (predicted.status == bdlm_pkg::STAT_EXHAUSTED) appends_refused++;
      if (cmd == bdlm_pkg::CMD_WALK_NEXT && predicted.status == bdlm_pkg::STAT_OK)
         walk_hits++;
      if (cmd == bdlm_pkg::CMD_RESET) screen_clears++;
   endtask

   // pool_size is only touched with the block idle and nothing outstanding
   task automatic write_pool_size(input logic [bdlm_pkg::POOL_SIZE_W-1:0] v);
      @(negedge clock);
      start <= 1'b0;
      while (awaited.size() != 0 || busy) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      pool_cfg = v;
      pool_writes++;
      @(posedge clock);
   endtask

   // begin walk, then step until the walk ends, max_steps beats went out or
   // the item budget is spent
   task automatic walk_screen(input logic scr, input int max_steps);
      draw_result_type got;
      int              s;
      send_command(bdlm_pkg::CMD_WALK_BEGIN, scr,
                   bdlm_pkg::LIST_NUM_W'($urandom_range(0, 63)), $urandom,
                   1'b0, '0, got);
      for (s = 0; s < max_steps && commands_sent < item_target; s++) begin
         send_command(bdlm_pkg::CMD_WALK_NEXT, 1'($urandom_range(0, 1)),
                      bdlm_pkg::LIST_NUM_W'($urandom_range(0, 63)), $urandom,
                      1'b0, '0, got);
         if (got.status == bdlm_pkg::STAT_WALK_DONE) break;
      end
   endtask

   // ------------------------------------------------------------------------
   // Result checker: every strobed beat must match the oldest awaited result.
   // Outputs are read right after the rising edge, i.e. pre-edge values.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : result_check
      draw_result_type seen;
      draw_result_type want;
      if (!reset && rsp_strobe) begin
         seen = {rsp_status, rsp_node_index, rsp_object_out, rsp_walk_list};
         if (awaited.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result beat, expected none, %s %0d %0d %h %0d",
                     $time, "got status/node/object/list", seen.status, seen.node,
                     seen.obj, seen.wlist);
         end else begin
            want = awaited.pop_front();
            if (seen !== want) begin
               mismatches++;
               $display("%0t: result beat differs, expected status %0d node %0d %s %h list %0d",
                        $time, want.status, want.node, "object", want.obj, want.wlist);
               $display("%0t:   got status %0d node %0d object %h list %0d",
                        $time, seen.status, seen.node, seen.obj, seen.wlist);
            end
         end
      end
   end

   // hard stop well past the slowest legal run
   initial begin
      #4_000_000;
      $display("%0t: timeout with %0d result beats outstanding", $time, awaited.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin : stimulus
      draw_result_type got;
      int              i;
      int              phase;
      int              k;
      int              r;
      logic [bdlm_pkg::POOL_SIZE_W-1:0] pv;

      // predictor reset state
      pool_cfg = bdlm_pkg::POOL_SIZE_RESET;
      alloc_cnt = '0;
      for (i = 0; i < ALL_LISTS; i++) begin
         list_head[i] = NIL;
         list_tail[i] = NIL;
      end
      cur_node = NIL;
      cur_list = 7'(SCREEN_LISTS);
      cur_scr = 1'b0;

      // Directed table. Typed results are the ones readable at a glance;
      // the rest go through the predictor.
      dir_rows.push_back(pool_row(9'd511));              // above pool: acts as 256
      // walk next with no walk active, then a walk over an empty screen
      dir_rows.push_back(op_row(bdlm_pkg::CMD_WALK_NEXT, 1'b0, 6'd0, 32'd0, 1'b1,
                                {bdlm_pkg::STAT_WALK_DONE, 8'd0, 32'd0, 6'd0}));
      dir_rows.push_back(op_row(bdlm_pkg::CMD_WALK_BEGIN, 1'b0, 6'd63, 32'hFFFF_FFFF, 1'b1,
                                {bdlm_pkg::STAT_OK, 8'd0, 32'd0, 6'd0}));
      dir_rows.push_back(op_row(bdlm_pkg::CMD_WALK_NEXT, 1'b0, 6'd0, 32'd0, 1'b1,
                                {bdlm_pkg::STAT_WALK_DONE, 8'd0, 32'd0, 6'd0}));
      // appends: first and last list, a link onto an old tail, a zero handle
      dir_rows.push_back(op_row(bdlm_pkg::CMD_APPEND, 1'b0, 6'd0, 32'hFFFF_FFFF, 1'b1,
                                {bdlm_pkg::STAT_OK, 8'd0, 32'd0, 6'd0}));
      dir_rows.push_back(op_row(bdlm_pkg::CMD_APPEND, 1'b0, 6'd63, 32'd1, 1'b1,
                                {bdlm_pkg::STAT_OK, 8'd1, 32'd0, 6'd0}));
      dir_rows.push_back(op_row(bdlm_pkg::CMD_APPEND, 1'b0, 6'd0, 32'h1234_5678, 1'b1,
                                {bdlm_pkg::STAT_OK, 8'd2, 32'd0, 6'd0}));
      dir_rows.push_back(op_row(bdlm_pkg::CMD_APPEND, 1'b1, 6'd5, 32'd0, 1'b1,
                                {bdlm_pkg::STAT_OK, 8'd3, 32'd0, 6'd0}));
      dir_rows.push_back(op_row(bdlm_pkg::CMD_APPEND, 1'b1, 6'd5, 32'hA5A5_A5A5, 1'b1,
                                {bdlm_pkg::STAT_OK, 8'd4, 32'd0, 6'd0}));
      // full walk of screen 0 in list order
      dir_rows.push_back(op_row(bdlm_pkg::CMD_WALK_BEGIN, 1'b0, 6'd0, 32'd0, 1'b1,
                                {bdlm_pkg::STAT_OK, 8'd0, 32'd0, 6'd0}));
      dir_rows.push_back(op_row(bdlm_pkg::CMD_WALK_NEXT, 1'b0, 6'd0, 32'd0, 1'b1,
                                {bdlm_pkg::STAT_OK, 8'd0, 32'hFFFF_FFFF, 6'd0}));
      dir_rows.push_back(op_row(bdlm_pkg::CMD_WALK_NEXT, 1'b0, 6'd0, 32'd0, 1'b1,
                                {bdlm_pkg::STAT_OK, 8'd2, 32'h1234_5678, 6'd0}));
      dir_rows.push_back(op_row(bdlm_pkg::CMD_WALK_NEXT, 1'b0, 6'd0, 32'd0, 1'b1,
                                {bdlm_pkg::STAT_OK, 8'd1, 32'd1, 6'd63}));
      dir_rows.push_back(op_row(bdlm_pkg::CMD_WALK_NEXT, 1'b0, 6'd0, 32'd0, 1'b1,
                                {bdlm_pkg::STAT_WALK_DONE, 8'd0, 32'd0, 6'd0}));
      // zero handle at the head of screen 1 list 5 hides the node behind it
      dir_rows.push_back(op_row(bdlm_pkg::CMD_WALK_BEGIN, 1'b1, 6'd0, 32'd0, 1'b1,
                                {bdlm_pkg::STAT_OK, 8'd0, 32'd0, 6'd0}));
      dir_rows.push_back(op_row(bdlm_pkg::CMD_WALK_NEXT, 1'b1, 6'd0, 32'd0, 1'b1,
                                {bdlm_pkg::STAT_WALK_DONE, 8'd0, 32'd0, 6'd0}));
      // clearing the walked screen ends the walk
      dir_rows.push_back(op_row(bdlm_pkg::CMD_WALK_BEGIN, 1'b0, 6'd0, 32'd0, 1'b0, '0));
      dir_rows.push_back(op_row(bdlm_pkg::CMD_RESET, 1'b0, 6'd0, 32'd0, 1'b1,
                                {bdlm_pkg::STAT_OK, 8'd0, 32'd0, 6'd0}));
      dir_rows.push_back(op_row(bdlm_pkg::CMD_WALK_NEXT, 1'b0, 6'd0, 32'd0, 1'b1,
                                {bdlm_pkg::STAT_WALK_DONE, 8'd0, 32'd0, 6'd0}));
      // pool freed but screen 1 kept its links: node 0 goes out again
      dir_rows.push_back(op_row(bdlm_pkg::CMD_APPEND, 1'b1, 6'd5, 32'hDEAD_BEEF, 1'b1,
                                {bdlm_pkg::STAT_OK, 8'd0, 32'd0, 6'd0}));
      // pool_size 0 acts as 1: the next append is refused
      dir_rows.push_back(pool_row(9'd0));
      dir_rows.push_back(op_row(bdlm_pkg::CMD_APPEND, 1'b0, 6'd10, 32'h0000_0042, 1'b1,
                                {bdlm_pkg::STAT_EXHAUSTED, 8'd0, 32'd0, 6'd0}));
      dir_rows.push_back(op_row(bdlm_pkg::CMD_RESET, 1'b1, 6'd0, 32'd0, 1'b1,
                                {bdlm_pkg::STAT_OK, 8'd0, 32'd0, 6'd0}));
      dir_rows.push_back(op_row(bdlm_pkg::CMD_APPEND, 1'b0, 6'd10, 32'h8000_0000, 1'b1,
                                {bdlm_pkg::STAT_OK, 8'd0, 32'd0, 6'd0}));
      dir_rows.push_back(op_row(bdlm_pkg::CMD_APPEND, 1'b0, 6'd11, 32'h0000_0007, 1'b1,
                                {bdlm_pkg::STAT_EXHAUSTED, 8'd0, 32'd0, 6'd0}));
      dir_rows.push_back(pool_row(9'd300));
      dir_rows.push_back(op_row(bdlm_pkg::CMD_APPEND, 1'b1, 6'd63, 32'h7FFF_FFFF, 1'b0, '0));

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_csr) write_pool_size(dir_rows[i].pool);
         else send_command(dir_rows[i].cmd, dir_rows[i].scr, dir_rows[i].lst,
                           dir_rows[i].obj, dir_rows[i].typed, dir_rows[i].want, got);
      end

      // Random phases, each under its own pool size. Phase 0 fills the pool
      // past exhaustion and walks it; phase 3 runs with no idle cycles.
      item_target = RANDOM_ITEMS + dir_rows.size();
      for (phase = 0; commands_sent < item_target; phase++) begin
         case (phase % 8)
            0:       pv = 9'd256;
            1:       pv = 9'd0;
            2:       pv = 9'($urandom_range(2, 12));
            3:       pv = 9'd511;
            4:       pv = 9'($urandom_range(257, 510));
            5:       pv = 9'd1;
            6:       pv = 9'($urandom_range(13, 255));
            default: pv = 9'($urandom_range(0, 511));
         endcase
         write_pool_size(pv);
         idle_pct = (phase == 3) ? 0 : 34;

         if (phase == 0) begin
            send_command(bdlm_pkg::CMD_RESET, 1'($urandom_range(0, 1)), 6'd0, 32'd0,
                         1'b0, '0, got);
            repeat (270)
               send_command(bdlm_pkg::CMD_APPEND, 1'($urandom_range(0, 1)), pick_list(),
                            pick_handle(), 1'b0, '0, got);
            walk_screen(1'b0, 300);
            walk_screen(1'b1, 300);
         end

         for (k = 0; k < 110 && commands_sent < item_target; k++) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
               send_command(bdlm_pkg::CMD_APPEND, 1'($urandom_range(0, 1)), pick_list(),
                            pick_handle(), 1'b0, '0, got);
            end else if (r < 56) begin
               send_command(bdlm_pkg::CMD_RESET, 1'($urandom_range(0, 1)),
                            bdlm_pkg::LIST_NUM_W'($urandom_range(0, 63)), $urandom,
                            1'b0, '0, got);
            end else if (r < 80) begin
               // a third of the walks run to the end, the rest stop early
               walk_screen(1'($urandom_range(0, 1)),
                           ($urandom_range(0, 2) == 0) ? 300 : $urandom_range(1, 12));
            end else begin
               send_command(bdlm_pkg::CMD_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                            bdlm_pkg::LIST_NUM_W'($urandom_range(0, 63)), $urandom,
                            1'b0, '0, got);
            end
         end
      end

      @(negedge clock);
      start <= 1'b0;
      while (awaited.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Ran %0d command beats over %0d random phases and %0d pool_size writes.",
               commands_sent, phase, pool_writes);
      $display("Appends placed %0d / refused %0d, walk steps with an object %0d, clears %0d.",
               appends_ok, appends_refused, walk_hits, screen_clears);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== bucketed_draw_list_manager.f =====
hdl/bdlm_pkg.sv
hdl/bdlm_node_store.sv
hdl/bucketed_draw_list_manager.sv
tb/bucketed_draw_list_manager_tb.sv
